/* rtl/core/rtps_pkg.sv */
// Shared types and constants for the ready table priority selector.
// Used by rtps_cell, rtps_ctrl and ready_table_priority_select.
// No dependencies.
`default_nettype none

package rtps_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_PORT_W = 4;
  localparam int IDX_CMP_W   = (SLOT_W > SLOT_PORT_W) ? SLOT_W : SLOT_PORT_W;
  localparam int PID_W       = 8;
  localparam int PRIO_W      = 8;
  localparam int ARR_W       = 16;

  typedef logic [SLOT_W-1:0]      slot_idx_t;
  typedef logic [SLOT_PORT_W-1:0] slot_port_t;
  typedef logic [PID_W-1:0]       pid_t;
  typedef logic [PRIO_W-1:0]      prio_t;
  typedef logic [ARR_W-1:0]       arr_t;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SELECT = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Data written into one slot.
  typedef struct packed {
    logic  valid;
    pid_t  pid;
    prio_t prio;
    arr_t  arrival;
  } entry_t;

  // Running best candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic      tag;
    logic      have;
    slot_idx_t pos;
    slot_idx_t slot;
    pid_t      pid;
    prio_t     prio;
    arr_t      arrival;
  } cand_t;

  // Control signals from the controller to the table.
  typedef struct packed {
    logic wr_en;
    logic launch;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/ready_table_priority_select.sv */
// Top level of the ready table priority selector: controller plus a chain of
// SLOTS cells. Depends on rtps_pkg, rtps_ctrl and rtps_cell.
//
//   channel   handshake            payload
//   command   start, busy          kind, slot, entry_valid, process_id,
//                                  prio_level, arrival
//   result    done (one cycle)     found, winner_slot, winner_id
//
// A write item is stored into its slot and the block stays ready.
// A select item sends a candidate down the chain, one cell per cycle; the
// result shows on done when the candidate leaves the last cell, and busy
// drops in the cycle after.
// Synchronous reset empties every slot and aborts any scan in flight.
// The receiver cannot stall; results are shown for exactly one cycle.
`default_nettype none

module ready_table_priority_select (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind,
  input  logic [3:0]               slot,
  input  logic                     entry_valid,
  input  logic [7:0]               process_id,
  input  logic [7:0]               prio_level,
  input  logic [15:0]              arrival,
  output logic                     done,
  output logic                     found,
  output logic [3:0]               winner_slot,
  output logic [7:0]               winner_id
);
  import rtps_pkg::*;

  ctrl_t  ctrl;
  entry_t wr_data;
  cand_t  launch_cand;
  cand_t  chain [SLOTS+1];
  cand_t  last;

  rtps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .scan_done (last.tag),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  assign wr_data.valid   = entry_valid;
  assign wr_data.pid     = process_id;
  assign wr_data.prio    = prio_level;
  assign wr_data.arrival = arrival;

  // The first cell sees an empty candidate tagged by the launch pulse.
  always_comb begin
    launch_cand     = '0;
    launch_cand.tag = ctrl.launch;
  end

  assign chain[0] = launch_cand;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic cell_wr;

    // Writes to an index with no cell match nothing and are dropped.
    assign cell_wr = ctrl.wr_en &&
                     (IDX_CMP_W'(slot) == IDX_CMP_W'(i));

    rtps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (cell_wr),
      .wr_data  (wr_data),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end

  assign last        = chain[SLOTS];
  assign done        = last.tag;
  assign found       = last.have;
  assign winner_slot = last.have ? SLOT_PORT_W'({{SLOT_PORT_W{1'b0}}, last.slot}) : '0;
  assign winner_id   = last.have ? last.pid : '0;

endmodule

`default_nettype wire

/* rtl/core/rtps_cell.sv */
// One slot of the ready table plus its stage of the selection chain.
// Depends on rtps_pkg.
`default_nettype none

module rtps_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rtps_pkg::entry_t wr_data,
  input  rtps_pkg::cand_t  cand_in,
  output rtps_pkg::cand_t  cand_out
);
  import rtps_pkg::*;

  logic   entry_valid;
  pid_t   entry_pid;
  prio_t  entry_prio;
  arr_t   entry_arrival;
  logic   own_beats;
  logic   take_own;
  cand_t  cand_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (wr_en) begin
      entry_valid <= wr_data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_pid     <= wr_data.pid;
      entry_prio    <= wr_data.prio;
      entry_arrival <= wr_data.arrival;
    end
  end

  // The incoming candidate comes from lower slots, so this slot only wins
  // when it is strictly better; exact ties keep the lower slot.
  always_comb begin
    if (entry_prio != cand_in.prio) begin
      own_beats = (entry_prio < cand_in.prio);
    end else if (entry_arrival != cand_in.arrival) begin
      own_beats = (entry_arrival < cand_in.arrival);
    end else begin
      own_beats = (entry_pid < cand_in.pid);
    end
  end

  assign take_own = entry_valid && (!cand_in.have || own_beats);

  always_comb begin
    cand_next     = cand_in;
    cand_next.pos = cand_in.pos + slot_idx_t'(1);
    if (take_own) begin
      cand_next.have    = 1'b1;
      cand_next.slot    = cand_in.pos;
      cand_next.pid     = entry_pid;
      cand_next.prio    = entry_prio;
      cand_next.arrival = entry_arrival;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else begin
      cand_out <= cand_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rtps_ctrl.sv */
// Command controller: accepts items, starts a scan and waits for it to leave
// the end of the cell chain. Depends on rtps_pkg.
`default_nettype none

module rtps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            kind,
  input  logic            scan_done,
  output logic            busy,
  output rtps_pkg::ctrl_t ctrl
);
  import rtps_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_SELECT)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    ctrl.wr_en  = 1'b0;
    ctrl.launch = 1'b0;
    case (state)
      ST_IDLE: begin
        ctrl.wr_en  = accept && (kind == KIND_WRITE);
        ctrl.launch = accept && (kind == KIND_SELECT);
      end
      ST_SCAN: begin
        busy = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* tb/sv/ready_table_priority_select_chk.sv */
// Checker for the ready table priority selector: keeps its own copy of the
// slot table, predicts the pick of every select item and compares the results.
// Depends on rtps_pkg.
`timescale 1ns / 1ps

module ready_table_priority_select_chk
  import rtps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       kind,
  input  logic [3:0] slot,
  input  logic       entry_valid,
  input  logic [7:0] process_id,
  input  logic [7:0] prio_level,
  input  logic [15:0] arrival,
  input  logic       done,
  input  logic       found,
  input  logic [3:0] winner_slot,
  input  logic [7:0] winner_id,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic       found;
    slot_port_t slot;
    pid_t       id;
  } pick_t;

  logic  ready_valid [SLOTS];
  pid_t  ready_pid   [SLOTS];
  prio_t ready_prio  [SLOTS];
  arr_t  ready_arr   [SLOTS];

  pick_t expected_picks[$];

  // Lowest priority number wins, then earliest arrival, then smallest id.
  // Only strictly better slots replace the best, so exact ties keep the
  // lowest index.
  function automatic pick_t pick_ready();
    pick_t p;
    int    best;
    p    = '0;
    best = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (ready_valid[i]) begin
        if (!p.found ||
            ready_prio[i] < ready_prio[best] ||
            (ready_prio[i] == ready_prio[best] &&
             (ready_arr[i] < ready_arr[best] ||
              (ready_arr[i] == ready_arr[best] && ready_pid[i] < ready_pid[best])))) begin
          best = i;
          p.found = 1'b1;
        end
      end
    end
    if (p.found) begin
      p.slot = slot_port_t'(best);
      p.id   = ready_pid[best];
    end
    return p;
  endfunction

  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) ready_valid[i] = 1'b0;
      expected_picks.delete();
    end else begin
      if (done) begin
        if (expected_picks.size() == 0) begin
          $error("result with no select waiting: found=%0d slot=%0d id=%0d",
                 found, winner_slot, winner_id);
          fail_count++;
        end else begin
          want = expected_picks.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            fail_count++;
          end
          if (winner_slot !== want.slot) begin
            $error("winner_slot: expected %0d, got %0d", want.slot, winner_slot);
            fail_count++;
          end
          if (winner_id !== want.id) begin
            $error("winner_id: expected %0d, got %0d", want.id, winner_id);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (kind == KIND_SELECT) begin
          expected_picks.push_back(pick_ready());
        end else if (int'(slot) < SLOTS) begin
          ready_valid[slot] = entry_valid;
          ready_pid[slot]   = process_id;
          ready_prio[slot]  = prio_level;
          ready_arr[slot]   = arrival;
        end
      end
    end
    pending <= expected_picks.size();
  end

endmodule

/* tb/sv/ready_table_priority_select_tb.sv */
// Testbench top for the ready table priority selector: drives directed and
// random write and select items in random bursts and gives the verdict.
// Depends on rtps_pkg, ready_table_priority_select and its checker.
`timescale 1ns / 1ps

module ready_table_priority_select_tb;
  import rtps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        kind = 1'b0;
  logic [3:0]  slot = '0;
  logic        entry_valid = 1'b0;
  logic [7:0]  process_id = '0;
  logic [7:0]  prio_level = '0;
  logic [15:0] arrival = '0;
  logic        busy;
  logic        done;
  logic        found;
  logic [3:0]  winner_slot;
  logic [7:0]  winner_id;

  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 0;

  always #4 clk = ~clk;

  ready_table_priority_select u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .slot(slot),
    .entry_valid(entry_valid), .process_id(process_id), .prio_level(prio_level),
    .arrival(arrival), .done(done), .found(found), .winner_slot(winner_slot),
    .winner_id(winner_id)
  );

  ready_table_priority_select_chk u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .slot(slot),
    .entry_valid(entry_valid), .process_id(process_id), .prio_level(prio_level),
    .arrival(arrival), .done(done), .found(found), .winner_slot(winner_slot),
    .winner_id(winner_id), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ready_table_priority_select regression: fail");
      $finish;
    end
  end

  // Holds start until the item is taken; gaps come between bursts only.
  task automatic send_item(input kind_t k, input slot_port_t s, input logic v,
                           input pid_t p, input prio_t pr, input arr_t a);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    kind        <= k;
    slot        <= s;
    entry_valid <= v;
    process_id  <= p;
    prio_level  <= pr;
    arrival     <= a;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_slot(input slot_port_t s, input logic v, input pid_t p,
                            input prio_t pr, input arr_t a);
    send_item(KIND_WRITE, s, v, p, pr, a);
  endtask

  // Select items carry random values in the fields the block ignores.
  task automatic select_item();
    send_item(KIND_SELECT, slot_port_t'($urandom), 1'($urandom), pid_t'($urandom),
              prio_t'($urandom), arr_t'($urandom));
  endtask

  // The checker's count is registered, so let it settle before reading it.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    bit narrow;
    int r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, field extremes and each level of tie-break.
    select_item();
    write_slot(4'd0, 1'b1, 8'd255, 8'd255, 16'hFFFF);
    select_item();
    write_slot(4'd15, 1'b1, 8'd0, 8'd255, 16'hFFFF);
    select_item();
    write_slot(4'd7, 1'b1, 8'd128, 8'd255, 16'h0000);
    select_item();
    write_slot(4'd3, 1'b1, 8'd128, 8'd255, 16'h0000);
    select_item();
    write_slot(4'd9, 1'b1, 8'd200, 8'd0, 16'hFFFF);
    select_item();
    write_slot(4'd9, 1'b0, 8'd0, 8'd0, 16'h0000);
    drain();
    select_item();
    write_slot(4'd0, 1'b0, 8'd255, 8'd0, 16'h0000);
    write_slot(4'd3, 1'b0, 8'd0, 8'd0, 16'h0000);
    write_slot(4'd7, 1'b0, 8'd0, 8'd0, 16'h0000);
    write_slot(4'd15, 1'b0, 8'd0, 8'd0, 16'h0000);
    select_item();

    // Random: mostly writes and selects, narrow values half the time so that
    // ties at every level are common.
    for (int n = 0; n < 1750; n++) begin
      if (n % 350 == 349) begin
        drain();
        for (int i = 0; i < SLOTS; i++)
          write_slot(slot_port_t'(i), 1'b0, pid_t'($urandom), prio_t'($urandom),
                     arr_t'($urandom));
        select_item();
      end
      r = $urandom_range(0, 99);
      narrow = 1'($urandom_range(0, 1));
      if (r < 55) begin
        write_slot(slot_port_t'($urandom), ($urandom_range(0, 3) != 0),
                   narrow ? pid_t'($urandom_range(0, 3)) : pid_t'($urandom),
                   narrow ? prio_t'($urandom_range(0, 3)) : prio_t'($urandom),
                   narrow ? arr_t'($urandom_range(0, 3)) : arr_t'($urandom));
      end else if (r < 90) begin
        select_item();
      end else begin
        write_slot(slot_port_t'($urandom), 1'b0, pid_t'($urandom), prio_t'($urandom),
                   arr_t'($urandom));
      end
    end

    drain();
    repeat (SLOTS + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ready_table_priority_select regression: pass");
    end else begin
      $display("ready_table_priority_select regression: fail");
    end
    $finish;
  end

endmodule

/* ready_table_priority_select.f */
rtl/core/rtps_pkg.sv
rtl/core/rtps_cell.sv
rtl/core/rtps_ctrl.sv
rtl/core/ready_table_priority_select.sv
tb/sv/ready_table_priority_select_chk.sv
tb/sv/ready_table_priority_select_tb.sv
